FILE: design/alle_pkg.sv
// ---------------------------------------------------------------------------
// alle_pkg: shared types and constants of the array linked list engine
// Word layouts, operation and status codes, and the command and status
// groups that pass between the controller and the datapath.
// ---------------------------------------------------------------------------
package alle_pkg;

  localparam int LINK_W        = 6;
  localparam int NODE_W        = 5;
  localparam int DATA_W        = 32;
  localparam int MAX_NODES     = 32;
  localparam int POOL_SIZE_DEF = 32;

  localparam logic [LINK_W-1:0] NIL_IDX     = LINK_W'(32);
  localparam logic [DATA_W-1:0] ID_CLEAR    = 32'hFFFF_FFFF;
  localparam logic [DATA_W-1:0] GRADE_CLEAR = 32'hBF80_0000;

  localparam logic [1:0] OP_INSERT   = 2'd0;
  localparam logic [1:0] OP_DELETE   = 2'd1;
  localparam logic [1:0] OP_TRAVERSE = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_NO_SUCC = 2'd3;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [LINK_W-1:0] pred_index;
    logic [DATA_W-1:0] student_id;
    logic [DATA_W-1:0] grade_bits;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [NODE_W-1:0] node_index;
    logic [DATA_W-1:0] out_student_id;
    logic [DATA_W-1:0] out_grade_bits;
    logic [LINK_W-1:0] next_index;
    logic              last;
  } out_item_t;

  // link read address source
  typedef enum logic [1:0] {RD_FREE, RD_LIST, RD_PRED, RD_LINK} rd_src_t;
  // node register load source
  typedef enum logic [1:0] {NS_FREE, NS_LIST, NS_LINK} node_src_t;
  // link write address and data
  typedef enum logic {LW_NODE, LW_PRED} lw_addr_t;
  typedef enum logic [1:0] {LD_LIST, LD_LINK, LD_FREE, LD_NODE} lw_data_t;
  // result word built on an emit
  typedef enum logic [2:0] {
    EM_INS_HEAD, EM_INS_AFTER, EM_DEL, EM_TRV, EM_FULL, EM_EMPTY, EM_NO_SUCC
  } emit_t;

  typedef struct packed {
    logic      latch_in;
    logic      lrd_en;
    logic      drd_en;
    rd_src_t   rd_src;
    logic      node_ld;
    node_src_t node_src;
    logic      link_ld;
    logic      lw_en;
    lw_addr_t  lw_addr;
    lw_data_t  lw_data;
    logic      dset;
    logic      dclr;
    logic      fh_from_link;
    logic      fh_from_node;
    logic      lh_from_node;
    logic      lh_from_link;
    logic      cnt_clr;
    logic      cnt_inc;
    logic      emit_en;
    emit_t     emit;
  } cmd_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic       at_head;
    logic       fh_node;
    logic       lh_node;
    logic       rd_node;
    logic       trv_fin;
    logic       out_free;
  } stat_t;

endpackage

FILE: design/array_linked_list_engine.sv
// ---------------------------------------------------------------------------
// array_linked_list_engine: linked list with free list in a node pool
// Insert, delete and traverse on a singly linked list kept in link and
// data memories, with the free list threaded through the same links.
// ---------------------------------------------------------------------------
// Usage:
//   Input words (opcode, predecessor, id, grade) enter on in_valid/in_ready;
//   result words leave on out_valid/out_ready from an output register.
//   One operation is worked at a time; in_ready is high only between them.
//   The link memory has one read and one write port, so each link read is
//   registered before the dependent write uses it. Traverse gives one word
//   per cycle while the receiver takes them. An unused opcode gives no word.
//   A stalled receiver holds the result word and pauses the sequence at
//   its next result; no word is lost. Reset (rst_n low, synchronous)
//   empties the list, puts every node on the free list and clears the
//   stores at once through per-entry valid bits: no clearing pass.
// ---------------------------------------------------------------------------
module array_linked_list_engine import alle_pkg::*; #(
  parameter int POOL_SIZE = POOL_SIZE_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  cmd_t  cmd;
  stat_t stat;

  alle_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  alle_dp #(
    .POOL_SIZE (POOL_SIZE)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: design/alle_dp.sv
// ---------------------------------------------------------------------------
// alle_dp: datapath of the array linked list engine
// Link and data memories with per-entry valid bits, head registers, node
// and link holding registers, traverse counter and the result register.
// ---------------------------------------------------------------------------
module alle_dp import alle_pkg::*; #(
  parameter int POOL_SIZE = POOL_SIZE_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_data,
  input  cmd_t      cmd,
  output stat_t     stat,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int POOL_EFF = (POOL_SIZE < MAX_NODES) ? POOL_SIZE : MAX_NODES;
  localparam int AW       = $clog2(POOL_EFF);
  localparam logic [LINK_W-1:0] EFF_L   = LINK_W'(POOL_EFF);
  localparam logic [AW-1:0]     CNT_MAX = AW'(POOL_EFF - 1);

  // link value of an entry that was never written
  function automatic logic [LINK_W-1:0] link_init(input logic [AW-1:0] a);
    logic [LINK_W-1:0] succ;
    succ = LINK_W'(a) + LINK_W'(1);
    return (succ < EFF_L) ? succ : NIL_IDX;
  endfunction

  logic [LINK_W-1:0]   link_mem_r [POOL_EFF];
  logic [2*DATA_W-1:0] data_mem_r [POOL_EFF];
  logic [POOL_EFF-1:0] lvld_r, dvld_r;

  logic [LINK_W-1:0]   link_rd_r;
  logic                link_rd_vld_r;
  logic [AW-1:0]       link_rd_addr_r;
  logic [2*DATA_W-1:0] data_rd_r;
  logic                data_rd_vld_r;

  in_item_t          in_r;
  logic [AW-1:0]     node_r;
  logic [LINK_W-1:0] link_r;
  logic [AW-1:0]     cnt_r;
  logic [LINK_W-1:0] fh_r, fh_nxt;
  logic [LINK_W-1:0] lh_r, lh_nxt;
  out_item_t         out_r, out_nxt;
  logic              out_valid_r;

  logic [AW-1:0]       rd_a, lw_a, node_nxt;
  logic [LINK_W-1:0]   lw_d, lnk_rd, ins_next;
  logic [2*DATA_W-1:0] data_word;

  assign lnk_rd    = link_rd_vld_r ? link_rd_r : link_init(link_rd_addr_r);
  assign data_word = data_rd_vld_r ? data_rd_r : {ID_CLEAR, GRADE_CLEAR};

  always_comb begin
    unique case (cmd.rd_src)
      RD_FREE: rd_a = fh_r[AW-1:0];
      RD_LIST: rd_a = lh_r[AW-1:0];
      RD_PRED: rd_a = in_r.pred_index[AW-1:0];
      RD_LINK: rd_a = lnk_rd[AW-1:0];
      default: rd_a = lnk_rd[AW-1:0];
    endcase
  end

  always_comb begin
    unique case (cmd.node_src)
      NS_FREE: node_nxt = fh_r[AW-1:0];
      NS_LIST: node_nxt = lh_r[AW-1:0];
      NS_LINK: node_nxt = lnk_rd[AW-1:0];
      default: node_nxt = lnk_rd[AW-1:0];
    endcase
  end

  assign lw_a = (cmd.lw_addr == LW_PRED) ? in_r.pred_index[AW-1:0] : node_r;

  always_comb begin
    unique case (cmd.lw_data)
      LD_LIST: lw_d = lh_r;
      LD_LINK: lw_d = lnk_rd;
      LD_FREE: lw_d = fh_r;
      LD_NODE: lw_d = LINK_W'(node_r);
      default: lw_d = NIL_IDX;
    endcase
  end

  // memories: one read and one write address per cycle, registered read
  always_ff @(posedge clk) begin
    if (cmd.lw_en) begin
      link_mem_r[lw_a] <= lw_d;
    end
    if (cmd.lrd_en) begin
      link_rd_r      <= link_mem_r[rd_a];
      link_rd_vld_r  <= lvld_r[rd_a];
      link_rd_addr_r <= rd_a;
    end
    if (cmd.dset) begin
      data_mem_r[node_r] <= {in_r.student_id, in_r.grade_bits};
    end
    if (cmd.drd_en) begin
      data_rd_r     <= data_mem_r[rd_a];
      data_rd_vld_r <= dvld_r[rd_a];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvld_r <= '0;
      dvld_r <= '0;
    end else begin
      if (cmd.lw_en) begin
        lvld_r[lw_a] <= 1'b1;
      end
      // a cleared entry reads back as the reset pattern
      if (cmd.dset) begin
        dvld_r[node_r] <= 1'b1;
      end else if (cmd.dclr) begin
        dvld_r[node_r] <= 1'b0;
      end
    end
  end

  always_comb begin
    fh_nxt = fh_r;
    if (cmd.fh_from_link) begin
      fh_nxt = link_r;
    end else if (cmd.fh_from_node) begin
      fh_nxt = LINK_W'(node_r);
    end
    lh_nxt = lh_r;
    if (cmd.lh_from_node) begin
      lh_nxt = LINK_W'(node_r);
    end else if (cmd.lh_from_link) begin
      lh_nxt = lnk_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fh_r <= '0;
      lh_r <= NIL_IDX;
    end else begin
      fh_r <= fh_nxt;
      lh_r <= lh_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      in_r <= in_data;
    end
    if (cmd.node_ld) begin
      node_r <= node_nxt;
    end
    if (cmd.link_ld) begin
      link_r <= lnk_rd;
    end
    if (cmd.cnt_clr) begin
      cnt_r <= '0;
    end else if (cmd.cnt_inc) begin
      cnt_r <= cnt_r + AW'(1);
    end
  end

  // a predecessor that is the new node itself ends up linked to itself
  assign ins_next = (in_r.pred_index == LINK_W'(node_r)) ? LINK_W'(node_r) : link_r;

  always_comb begin
    out_nxt                = '0;
    out_nxt.status         = ST_OK;
    out_nxt.next_index     = NIL_IDX;
    out_nxt.last           = 1'b1;
    out_nxt.node_index     = NODE_W'(node_r);
    out_nxt.out_student_id = data_word[2*DATA_W-1:DATA_W];
    out_nxt.out_grade_bits = data_word[DATA_W-1:0];
    unique case (cmd.emit)
      EM_INS_HEAD:  out_nxt.next_index = lh_r;
      EM_INS_AFTER: out_nxt.next_index = ins_next;
      EM_DEL:       out_nxt.next_index = fh_r;
      EM_TRV: begin
        out_nxt.next_index = lnk_rd;
        out_nxt.last       = stat.trv_fin;
      end
      EM_FULL, EM_EMPTY, EM_NO_SUCC: begin
        out_nxt.status         = (cmd.emit == EM_FULL)  ? ST_FULL :
                                 (cmd.emit == EM_EMPTY) ? ST_EMPTY : ST_NO_SUCC;
        out_nxt.node_index     = (cmd.emit == EM_NO_SUCC) ?
                                 in_r.pred_index[NODE_W-1:0] : '0;
        out_nxt.out_student_id = '0;
        out_nxt.out_grade_bits = '0;
      end
      default: out_nxt.next_index = NIL_IDX;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_en) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_en) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign stat.opcode   = in_r.opcode;
  assign stat.at_head  = !(in_r.pred_index < EFF_L);
  assign stat.fh_node  = fh_r < EFF_L;
  assign stat.lh_node  = lh_r < EFF_L;
  assign stat.rd_node  = lnk_rd < EFF_L;
  assign stat.trv_fin  = !stat.rd_node || (cnt_r == CNT_MAX);
  assign stat.out_free = !out_valid_r || out_ready;

  a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_en |-> (!out_valid_r || out_ready))
    else $error("result loaded over a word not yet taken");

  a_link_port_single: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.lw_en && cmd.lrd_en))
    else $error("link memory read and written in one cycle");

  a_valid_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.emit_en))
    else $error("result valid without an emit");

endmodule

FILE: design/alle_ctrl.sv
// ---------------------------------------------------------------------------
// alle_ctrl: controller of the array linked list engine
// Sequences each operation as link memory reads and writes, and gates
// every result on a free output register.
// ---------------------------------------------------------------------------
module alle_ctrl import alle_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [11:0] {
    S_IDLE   = 12'b0000_0000_0001,
    S_DECODE = 12'b0000_0000_0010,
    S_INS_A  = 12'b0000_0000_0100,
    S_INS_H  = 12'b0000_0000_1000,
    S_INS_P  = 12'b0000_0001_0000,
    S_INS_Q  = 12'b0000_0010_0000,
    S_DEL_H  = 12'b0000_0100_0000,
    S_DEL_P  = 12'b0000_1000_0000,
    S_DEL_T  = 12'b0001_0000_0000,
    S_DEL_F  = 12'b0010_0000_0000,
    S_TRV    = 12'b0100_0000_0000,
    S_ERR    = 12'b1000_0000_0000
  } state_t;

  state_t state_r, state_nxt;
  emit_t  err_r, err_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    err_nxt   = err_r;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat.opcode)
          OP_INSERT: begin
            if (!stat.fh_node) begin
              err_nxt   = EM_FULL;
              state_nxt = S_ERR;
            end else begin
              cmd.lrd_en   = 1'b1;
              cmd.drd_en   = 1'b1;
              cmd.rd_src   = RD_FREE;
              cmd.node_ld  = 1'b1;
              cmd.node_src = NS_FREE;
              state_nxt    = S_INS_A;
            end
          end
          OP_DELETE: begin
            if (!stat.lh_node) begin
              err_nxt   = EM_EMPTY;
              state_nxt = S_ERR;
            end else if (stat.at_head) begin
              cmd.lrd_en   = 1'b1;
              cmd.drd_en   = 1'b1;
              cmd.rd_src   = RD_LIST;
              cmd.node_ld  = 1'b1;
              cmd.node_src = NS_LIST;
              state_nxt    = S_DEL_H;
            end else begin
              cmd.lrd_en = 1'b1;
              cmd.rd_src = RD_PRED;
              state_nxt  = S_DEL_P;
            end
          end
          OP_TRAVERSE: begin
            if (!stat.lh_node) begin
              err_nxt   = EM_EMPTY;
              state_nxt = S_ERR;
            end else begin
              cmd.lrd_en   = 1'b1;
              cmd.drd_en   = 1'b1;
              cmd.rd_src   = RD_LIST;
              cmd.node_ld  = 1'b1;
              cmd.node_src = NS_LIST;
              cmd.cnt_clr  = 1'b1;
              state_nxt    = S_TRV;
            end
          end
          default: state_nxt = S_IDLE;  // unused opcode: drop
        endcase
      end
      S_INS_A: begin
        // hold the old free successor, fetch the predecessor link if needed
        cmd.link_ld = 1'b1;
        if (stat.at_head) begin
          state_nxt = S_INS_H;
        end else begin
          cmd.lrd_en = 1'b1;
          cmd.rd_src = RD_PRED;
          state_nxt  = S_INS_P;
        end
      end
      S_INS_H: begin
        if (stat.out_free) begin
          cmd.lw_en        = 1'b1;
          cmd.lw_addr      = LW_NODE;
          cmd.lw_data      = LD_LIST;
          cmd.dset         = 1'b1;
          cmd.fh_from_link = 1'b1;
          cmd.lh_from_node = 1'b1;
          cmd.emit_en      = 1'b1;
          cmd.emit         = EM_INS_HEAD;
          state_nxt        = S_IDLE;
        end
      end
      S_INS_P: begin
        cmd.lw_en        = 1'b1;
        cmd.lw_addr      = LW_NODE;
        cmd.lw_data      = LD_LINK;
        cmd.dset         = 1'b1;
        cmd.fh_from_link = 1'b1;
        cmd.link_ld      = 1'b1;
        state_nxt        = S_INS_Q;
      end
      S_INS_Q: begin
        if (stat.out_free) begin
          cmd.lw_en   = 1'b1;
          cmd.lw_addr = LW_PRED;
          cmd.lw_data = LD_NODE;
          cmd.emit_en = 1'b1;
          cmd.emit    = EM_INS_AFTER;
          state_nxt   = S_IDLE;
        end
      end
      S_DEL_H: begin
        if (stat.out_free) begin
          cmd.lh_from_link = 1'b1;
          cmd.lw_en        = 1'b1;
          cmd.lw_addr      = LW_NODE;
          cmd.lw_data      = LD_FREE;
          cmd.dclr         = 1'b1;
          cmd.fh_from_node = 1'b1;
          cmd.emit_en      = 1'b1;
          cmd.emit         = EM_DEL;
          state_nxt        = S_IDLE;
        end
      end
      S_DEL_P: begin
        if (stat.rd_node) begin
          cmd.lrd_en   = 1'b1;
          cmd.drd_en   = 1'b1;
          cmd.rd_src   = RD_LINK;
          cmd.node_ld  = 1'b1;
          cmd.node_src = NS_LINK;
          state_nxt    = S_DEL_T;
        end else begin
          err_nxt   = EM_NO_SUCC;
          state_nxt = S_ERR;
        end
      end
      S_DEL_T: begin
        // bypass the victim
        cmd.lw_en   = 1'b1;
        cmd.lw_addr = LW_PRED;
        cmd.lw_data = LD_LINK;
        state_nxt   = S_DEL_F;
      end
      S_DEL_F: begin
        if (stat.out_free) begin
          cmd.lw_en        = 1'b1;
          cmd.lw_addr      = LW_NODE;
          cmd.lw_data      = LD_FREE;
          cmd.dclr         = 1'b1;
          cmd.fh_from_node = 1'b1;
          cmd.emit_en      = 1'b1;
          cmd.emit         = EM_DEL;
          state_nxt        = S_IDLE;
        end
      end
      S_TRV: begin
        if (stat.out_free) begin
          cmd.emit_en = 1'b1;
          cmd.emit    = EM_TRV;
          if (stat.trv_fin) begin
            state_nxt = S_IDLE;
          end else begin
            // advance: fetch the successor while its predecessor is sent
            cmd.lrd_en   = 1'b1;
            cmd.drd_en   = 1'b1;
            cmd.rd_src   = RD_LINK;
            cmd.node_ld  = 1'b1;
            cmd.node_src = NS_LINK;
            cmd.cnt_inc  = 1'b1;
          end
        end
      end
      S_ERR: begin
        if (stat.out_free) begin
          cmd.emit_en = 1'b1;
          cmd.emit    = err_r;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      err_r   <= EM_FULL;
    end else begin
      state_r <= state_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule

FILE: tb/sv/array_linked_list_engine_tb.sv
// ---------------------------------------------------------------------------
// array_linked_list_engine_tb: self-checking bench for the list engine
// Drives insert, delete, traverse and unused-opcode words with random gaps on both sides,
// tracks the node pool in a local copy of the links and stores, and checks
// every result word field by field against the words predicted for it.
// ---------------------------------------------------------------------------
module array_linked_list_engine_tb import alle_pkg::*; ();

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         STALL_LIMIT = 2000;
  localparam int         HOLD_CYCLES = 300;
  localparam int         TAIL_CYCLES = 20;

  typedef struct {
    in_item_t  word;
    bit        typed;
    out_item_t res;
  } dir_row_t;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  // local copy of the node pool
  logic [LINK_W-1:0] link_mem  [MAX_NODES];
  logic [DATA_W-1:0] id_mem    [MAX_NODES];
  logic [DATA_W-1:0] grade_mem [MAX_NODES];
  logic [LINK_W-1:0] list_hd;
  logic [LINK_W-1:0] free_hd;

  out_item_t         exp_q   [$];
  out_item_t         calc_q  [$];
  logic [LINK_W-1:0] chain_q [$];
  dir_row_t          dir_tab [$];
  out_item_t         want_w;

  int err_cnt    = 0;
  int stall_cnt  = 0;
  int hold_left  = 0;
  bit hold_req   = 1'b0;
  bit idle_on    = 1'b1;

  array_linked_list_engine u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic bit is_node(logic [LINK_W-1:0] v);
    return v < LINK_W'(MAX_NODES);
  endfunction

  function automatic out_item_t mk_res(logic [1:0] st, logic [NODE_W-1:0] nd,
                                       logic [DATA_W-1:0] id, logic [DATA_W-1:0] gr,
                                       logic [LINK_W-1:0] nx, logic fin);
    out_item_t r;
    r.status         = st;
    r.node_index     = nd;
    r.out_student_id = id;
    r.out_grade_bits = gr;
    r.next_index     = nx;
    r.last           = fin;
    return r;
  endfunction

  function automatic out_item_t err_res(logic [1:0] st, logic [NODE_W-1:0] nd);
    return mk_res(st, nd, '0, '0, NIL_IDX, 1'b1);
  endfunction

  function automatic in_item_t mk_word(logic [1:0] op, logic [LINK_W-1:0] pred,
                                       logic [DATA_W-1:0] id, logic [DATA_W-1:0] gr);
    in_item_t w;
    w.opcode     = op;
    w.pred_index = pred;
    w.student_id = id;
    w.grade_bits = gr;
    return w;
  endfunction

  function automatic dir_row_t mk_row(in_item_t w, bit typed, out_item_t res);
    dir_row_t r;
    r.word  = w;
    r.typed = typed;
    r.res   = res;
    return r;
  endfunction

  // NIL mostly, now and then another out-of-range index that also means head
  function automatic logic [LINK_W-1:0] head_pred();
    if ($urandom_range(0, 3) == 0) return LINK_W'($urandom_range(33, 63));
    return NIL_IDX;
  endfunction

  task automatic reset_pool();
    for (int i = 0; i < MAX_NODES; i++) begin
      link_mem[i]  = (i + 1 < MAX_NODES) ? LINK_W'(i + 1) : NIL_IDX;
      id_mem[i]    = ID_CLEAR;
      grade_mem[i] = GRADE_CLEAR;
    end
    list_hd = NIL_IDX;
    free_hd = '0;
  endtask

  // apply one word to the pool copy; leaves the words it causes in calc_q
  task automatic apply_word(input in_item_t w);
    logic [NODE_W-1:0] n;
    logic [NODE_W-1:0] p;
    logic [LINK_W-1:0] cur;
    logic [LINK_W-1:0] nx;
    logic [DATA_W-1:0] oid;
    logic [DATA_W-1:0] ogr;
    bit                at_head;
    int                k;
    calc_q.delete();
    at_head = !is_node(w.pred_index);
    p       = w.pred_index[NODE_W-1:0];
    case (w.opcode)
      OP_INSERT: begin
        if (!is_node(free_hd)) begin
          calc_q.push_back(err_res(ST_FULL, '0));
        end else begin
          n            = free_hd[NODE_W-1:0];
          free_hd      = link_mem[n];
          oid          = id_mem[n];
          ogr          = grade_mem[n];
          id_mem[n]    = w.student_id;
          grade_mem[n] = w.grade_bits;
          if (at_head) begin
            link_mem[n] = list_hd;
            list_hd     = {1'b0, n};
          end else begin
            link_mem[n] = link_mem[p];
            link_mem[p] = {1'b0, n};
          end
          calc_q.push_back(mk_res(ST_OK, n, oid, ogr, link_mem[n], 1'b1));
        end
      end
      OP_DELETE: begin
        // empty check wins over the predecessor check
        if (!is_node(list_hd)) begin
          calc_q.push_back(err_res(ST_EMPTY, '0));
        end else if (!at_head && !is_node(link_mem[p])) begin
          calc_q.push_back(err_res(ST_NO_SUCC, p));
        end else begin
          if (at_head) begin
            n       = list_hd[NODE_W-1:0];
            list_hd = link_mem[n];
          end else begin
            n           = link_mem[p][NODE_W-1:0];
            link_mem[p] = link_mem[n];
          end
          oid          = id_mem[n];
          ogr          = grade_mem[n];
          link_mem[n]  = free_hd;
          id_mem[n]    = ID_CLEAR;
          grade_mem[n] = GRADE_CLEAR;
          free_hd      = {1'b0, n};
          calc_q.push_back(mk_res(ST_OK, n, oid, ogr, link_mem[n], 1'b1));
        end
      end
      OP_TRAVERSE: begin
        if (!is_node(list_hd)) begin
          calc_q.push_back(err_res(ST_EMPTY, '0));
        end else begin
          cur = list_hd;
          k   = 0;
          // stop at nil or after one word per node
          while (is_node(cur) && k < MAX_NODES) begin
            nx = link_mem[cur[NODE_W-1:0]];
            calc_q.push_back(mk_res(ST_OK, cur[NODE_W-1:0], id_mem[cur[NODE_W-1:0]],
                                    grade_mem[cur[NODE_W-1:0]], nx,
                                    !is_node(nx) || (k + 1 >= MAX_NODES)));
            k++;
            cur = nx;
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic walk_list();
    logic [LINK_W-1:0] cur;
    int                k;
    chain_q.delete();
    cur = list_hd;
    k   = 0;
    while (is_node(cur) && k < MAX_NODES) begin
      chain_q.push_back(cur);
      cur = link_mem[cur[NODE_W-1:0]];
      k++;
    end
  endtask

  task automatic report_mismatch(input string msg);
    err_cnt++;
    $display("MISMATCH at %0t: %s", $realtime, msg);
  endtask

  task automatic cmp_field(input string name, input logic [DATA_W-1:0] got,
                           input logic [DATA_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
  endtask

  // offer one word, hold it until taken, then record what it should cause
  task automatic send_word(input in_item_t w, input bit typed, input out_item_t tres);
    @(negedge clk);
    while (idle_on && $urandom_range(0, 99) < 10) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    apply_word(w);
    if (typed) exp_q.push_back(tres);
    else foreach (calc_q[i]) exp_q.push_back(calc_q[i]);
  endtask

  task automatic send_rand_op();
    int                r;
    logic [1:0]        op;
    logic [LINK_W-1:0] pred;
    walk_list();
    r    = $urandom_range(0, 99);
    pred = head_pred();
    if (r < 45) begin
      op = OP_INSERT;
      if (chain_q.size() != 0 && $urandom_range(0, 99) < 60)
        pred = chain_q[$urandom_range(0, chain_q.size() - 1)];
    end else if (r < 80) begin
      op = OP_DELETE;
      if (chain_q.size() != 0 && $urandom_range(0, 99) < 65)
        pred = chain_q[$urandom_range(0, chain_q.size() - 1)];
    end else if (r < 92) begin
      op = OP_TRAVERSE;
    end else begin
      // noise: unused opcode, or a predecessor that may be off the list
      op   = (r < 96) ? OP_UNUSED : ($urandom_range(0, 1) ? OP_DELETE : OP_INSERT);
      pred = LINK_W'($urandom_range(0, 31));
    end
    send_word(mk_word(op, pred, $urandom, $urandom), 1'b0, '0);
  endtask

  task automatic fill_pool();
    logic [LINK_W-1:0] pred;
    int                guard;
    guard = 0;
    while (is_node(free_hd) && guard < 40) begin
      walk_list();
      pred = head_pred();
      if (chain_q.size() != 0 && $urandom_range(0, 1))
        pred = chain_q[$urandom_range(0, chain_q.size() - 1)];
      send_word(mk_word(OP_INSERT, pred, $urandom, $urandom), 1'b0, '0);
      guard++;
    end
    // one more to hit the full pool
    send_word(mk_word(OP_INSERT, NIL_IDX, $urandom, $urandom), 1'b0, '0);
  endtask

  task automatic drain_pool();
    logic [LINK_W-1:0] pred;
    int                guard;
    guard = 0;
    while (is_node(list_hd) && guard < 40) begin
      walk_list();
      pred = head_pred();
      if (chain_q.size() > 1 && $urandom_range(0, 1))
        pred = chain_q[$urandom_range(0, chain_q.size() - 2)];
      send_word(mk_word(OP_DELETE, pred, $urandom, $urandom), 1'b0, '0);
      guard++;
    end
    send_word(mk_word(OP_DELETE, head_pred(), $urandom, $urandom), 1'b0, '0);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (exp_q.size() != 0) @(posedge clk);
    // allow for a word that causes no result still in flight
    repeat (4) @(posedge clk);
  endtask

  task automatic build_table();
    dir_tab.push_back(mk_row(mk_word(OP_TRAVERSE, NIL_IDX, '0, '0), 1'b1,
                             err_res(ST_EMPTY, '0)));
    dir_tab.push_back(mk_row(mk_word(OP_DELETE, NIL_IDX, '0, '0), 1'b1,
                             err_res(ST_EMPTY, '0)));
    // empty list answers before the predecessor is looked at
    dir_tab.push_back(mk_row(mk_word(OP_DELETE, 6'd7, '1, '1), 1'b1,
                             err_res(ST_EMPTY, '0)));
    dir_tab.push_back(mk_row(mk_word(OP_INSERT, NIL_IDX, '0, '0), 1'b1,
                             mk_res(ST_OK, 5'd0, ID_CLEAR, GRADE_CLEAR, NIL_IDX, 1'b1)));
    // top index is out of range, so act at the head
    dir_tab.push_back(mk_row(mk_word(OP_INSERT, 6'd63, '1, '1), 1'b1,
                             mk_res(ST_OK, 5'd1, ID_CLEAR, GRADE_CLEAR, 6'd0, 1'b1)));
    dir_tab.push_back(mk_row(mk_word(OP_DELETE, 6'd0, '0, '0), 1'b1,
                             err_res(ST_NO_SUCC, 5'd0)));
    dir_tab.push_back(mk_row(mk_word(OP_INSERT, 6'd0, 32'hA5A5_A5A5, 32'h3F80_0000),
                             1'b0, '0));
    dir_tab.push_back(mk_row(mk_word(OP_INSERT, 6'd2, 32'h5A5A_5A5A, 32'h8000_0000),
                             1'b0, '0));
    dir_tab.push_back(mk_row(mk_word(OP_TRAVERSE, NIL_IDX, '0, '0), 1'b0, '0));
    dir_tab.push_back(mk_row(mk_word(OP_DELETE, 6'd1, '0, '0), 1'b0, '0));
    dir_tab.push_back(mk_row(mk_word(OP_DELETE, 6'd45, '0, '0), 1'b0, '0));
    // predecessors taken from the free list rather than the data list
    dir_tab.push_back(mk_row(mk_word(OP_INSERT, 6'd10, 32'h1234_5678, 32'hDEAD_BEEF),
                             1'b0, '0));
    dir_tab.push_back(mk_row(mk_word(OP_DELETE, 6'd20, '0, '0), 1'b0, '0));
    dir_tab.push_back(mk_row(mk_word(OP_UNUSED, 6'd63, '1, '1), 1'b0, '0));
    dir_tab.push_back(mk_row(mk_word(OP_INSERT, 6'd31, 32'h0000_0001, 32'h7F7F_FFFF),
                             1'b0, '0));
    dir_tab.push_back(mk_row(mk_word(OP_TRAVERSE, 6'd5, '1, '0), 1'b0, '0));
    dir_tab.push_back(mk_row(mk_word(OP_DELETE, NIL_IDX, '0, '0), 1'b0, '0));
    dir_tab.push_back(mk_row(mk_word(OP_TRAVERSE, NIL_IDX, '0, '0), 1'b0, '0));
  endtask

  // receiver: random back-pressure plus one long hold on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !(idle_on && $urandom_range(0, 99) < 10);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (exp_q.size() == 0) begin
        report_mismatch($sformatf("result word with nothing expected, node %0d",
                                  out_data.node_index));
      end else begin
        want_w = exp_q.pop_front();
        cmp_field("status", DATA_W'(out_data.status), DATA_W'(want_w.status));
        cmp_field("node_index", DATA_W'(out_data.node_index),
                  DATA_W'(want_w.node_index));
        cmp_field("out_student_id", out_data.out_student_id, want_w.out_student_id);
        cmp_field("out_grade_bits", out_data.out_grade_bits, want_w.out_grade_bits);
        cmp_field("next_index", DATA_W'(out_data.next_index),
                  DATA_W'(want_w.next_index));
        cmp_field("last", DATA_W'(out_data.last), DATA_W'(want_w.last));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cnt = 0;
    end else begin
      stall_cnt++;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    reset_pool();
    build_table();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) send_word(dir_tab[i].word, dir_tab[i].typed, dir_tab[i].res);

    repeat (40) send_rand_op();
    fill_pool();
    // hold the receiver through a full traverse and keep offering words
    hold_req = 1'b1;
    send_word(mk_word(OP_TRAVERSE, NIL_IDX, $urandom, $urandom), 1'b0, '0);
    repeat (5) send_rand_op();

    idle_on = 1'b0;
    repeat (40) send_rand_op();
    idle_on = 1'b1;

    drain_pool();
    wait_drained();
    repeat (60) send_rand_op();

    @(negedge clk);
    in_valid <= 1'b0;
    while (exp_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: files.f
design/alle_pkg.sv
design/alle_dp.sv
design/alle_ctrl.sv
design/array_linked_list_engine.sv
tb/sv/array_linked_list_engine_tb.sv
